// ===== hdl/bitmap_disk_erase_and_probe_core_defines.svh =====
// Assertion macros for the bitmap disk erase and probe core.
`ifndef BITMAP_DISK_ERASE_AND_PROBE_CORE_DEFINES_SVH
`define BITMAP_DISK_ERASE_AND_PROBE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDEP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdep assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BDEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdep assertion failed");

`endif

// ===== hdl/bdep_pkg.sv =====
// Shared types, constants and helper functions of the bitmap disk erase and probe core.
package bdep_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_PROBE = 2'd2;

    localparam logic [7:0] ALPHA_NONE = 8'h00;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    localparam int CRD_W    = 14;
    localparam int SQ_IN_W  = 19;
    localparam int SQ_OUT_W = 2 * SQ_IN_W;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] CFG_STAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_STAGE_HEIGHT = 2'd1;

    function automatic logic signed [CRD_W-1:0] clip_coord(
        input logic signed [CRD_W-1:0] v,
        input logic signed [CRD_W-1:0] hi
    );
        logic signed [CRD_W-1:0] res;
        begin
            if (v < $signed(CRD_W'(0)))
            begin
                res = '0;
            end
            else if (v > hi)
            begin
                res = hi;
            end
            else
            begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

// ===== hdl/bdep_sq_unit.sv =====
// Shared registered squaring unit used for radius and distance terms.
module bdep_sq_unit
(
    input  logic                                  clk,
    input  logic signed [bdep_pkg::SQ_IN_W-1:0]   op,
    output logic        [bdep_pkg::SQ_OUT_W-1:0]  sq_q
);

    logic signed [bdep_pkg::SQ_OUT_W-1:0] prod;

    assign prod = op * op;

    always_ff @(posedge clk)
    begin
        sq_q <= $unsigned(prod);
    end

endmodule

// ===== hdl/bdep_alpha_mem.sv =====
// Pixel alpha memory with one write port and one registered read port.
module bdep_alpha_mem
#(
    parameter int DEPTH = 262144
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [7:0]                wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [7:0]                rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/bitmap_disk_erase_and_probe_core.sv =====
// Top level of the bitmap disk erase and probe core: sequencer, window scan and ports.
//
// Input transactions arrive on s_tvalid/s_tready with the kind in s_tuser and the
// load and disk fields in s_tdata. Every transaction returns one result transaction
// on m_tvalid/m_tready. Stage width and height are set over the APB port (offsets 0
// and 4). The user must write them only while the core is idle; the core itself
// does not enforce this. A load writes one pixel at acceptance; its result is then
// posted from ST_DONE. Erase and probe scan the clipped square window through the
// single memory read port and the shared squaring unit, one pixel per cycle within
// a window row: ST_SETUP and ST_LIM, then ST_ROW, ST_ROW2, ST_SCAN and ST_TAIL for
// each window row, then ST_DONE to post the result. A probe stops at its first hit.
// s_tready is high only while the core is idle; one transaction is in work at a time.
// The result is held in an output register; a new transaction is accepted while it
// waits, and the next result waits until the receiver takes the previous one.
// Reset returns the sequencer to idle, drops m_tvalid and sets both stage registers
// to 512. Pixel memory is not cleared; each pixel must be loaded before it is read.
`include "bitmap_disk_erase_and_probe_core_defines.svh"

module bitmap_disk_erase_and_probe_core
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_RADIUS = 63
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // fields from bit 0: load_x[8:0], load_y[8:0], load_alpha[7:0],
    // center_x[15:0], center_y[15:0], radius[5:0]
    input  logic [bdep_pkg::IN_DATA_W-1:0]      s_tdata,
    // fields from bit 0: kind[1:0]
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: hit, hit_x[8:0], hit_y[8:0], erased_count[13:0], zero pad
    output logic [bdep_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = bdep_pkg::CRD_W;
    localparam int SIW = bdep_pkg::SQ_IN_W;
    localparam int SOW = bdep_pkg::SQ_OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LIM,
        ST_ROW,
        ST_ROW2,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [9:0] stage_width_reg;
    logic [9:0] stage_height_reg;

    logic [1:0]         kind_reg;
    logic signed [15:0] cx_reg;
    logic signed [15:0] cy_reg;
    logic [5:0]         r_reg;

    logic [YW-1:0] re_reg;
    logic [XW-1:0] cs_reg;
    logic [XW-1:0] ce_reg;
    logic [YW-1:0] row_reg;
    logic [XW-1:0] col_reg;
    logic [AW-1:0] row_base_reg;
    logic [SOW-1:0] lim_reg;
    logic [SOW-1:0] dy2_reg;

    logic          p_valid_reg;
    logic [XW-1:0] p_col_reg;
    logic [AW-1:0] p_addr_reg;

    logic        res_hit_reg;
    logic [8:0]  res_hx_reg;
    logic [8:0]  res_hy_reg;
    logic [13:0] res_count_reg;

    logic                               m_tvalid_reg;
    logic [bdep_pkg::OUT_DATA_W-1:0]    m_tdata_reg;

    logic [8:0]  in_load_x;
    logic [8:0]  in_load_y;
    logic [7:0]  in_load_alpha;
    logic [15:0] in_center_x;
    logic [15:0] in_center_y;
    logic [5:0]  in_radius;
    logic        in_accept;
    logic        ld_ok;
    logic [AW-1:0] ld_addr;

    logic [5:0]            r_eff;
    logic signed [CW-1:0]  w_eff;
    logic signed [CW-1:0]  h_eff;
    logic signed [16:0]    cx_rnd;
    logic signed [16:0]    cy_rnd;
    logic signed [CW-1:0]  rx;
    logic signed [CW-1:0]  ry;
    logic signed [CW-1:0]  r_s;
    logic signed [CW-1:0]  rs_v;
    logic signed [CW-1:0]  re_v;
    logic signed [CW-1:0]  cs_v;
    logic signed [CW-1:0]  ce_v;

    logic signed [SIW-1:0] sq_op;
    logic [SOW-1:0]        sq_q;
    logic signed [SIW-1:0] cx_ext;
    logic signed [SIW-1:0] cy_ext;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    logic ev_inside;
    logic erase_hit;
    logic probe_hit;
    logic col_last;
    logic row_last;
    logic cfg_wr;

    assign in_load_x     = s_tdata[8:0];
    assign in_load_y     = s_tdata[17:9];
    assign in_load_alpha = s_tdata[25:18];
    assign in_center_x   = s_tdata[41:26];
    assign in_center_y   = s_tdata[57:42];
    assign in_radius     = s_tdata[63:58];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == bdep_pkg::CFG_STAGE_HEIGHT[0]) ?
                    {22'd0, stage_height_reg} : {22'd0, stage_width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_width_reg  <= 10'd512;
            stage_height_reg <= 10'd512;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bdep_pkg::CFG_STAGE_HEIGHT[0])
            begin
                stage_height_reg <= pwdata[9:0];
            end
            else
            begin
                stage_width_reg <= pwdata[9:0];
            end
        end
    end

    assign ld_ok   = (32'(in_load_x) < 32'(MAX_WIDTH)) && (32'(in_load_y) < 32'(MAX_HEIGHT));
    assign ld_addr = AW'(32'(in_load_y) * 32'(MAX_WIDTH) + 32'(in_load_x));

    assign r_eff = (32'(r_reg) > 32'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : r_reg;

    always_comb
    begin
        if (stage_width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(stage_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(stage_width_reg);
        end
        if (stage_height_reg == '0)
        begin
            h_eff = CW'(1);
        end
        else if (32'(stage_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = CW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = CW'(stage_height_reg);
        end
    end

    assign cx_rnd = ($signed({cx_reg[15], cx_reg}) + 17'sd8) >>> 4;
    assign cy_rnd = ($signed({cy_reg[15], cy_reg}) + 17'sd8) >>> 4;
    assign rx     = $signed(cx_rnd[CW-1:0]);
    assign ry     = $signed(cy_rnd[CW-1:0]);
    assign r_s    = $signed({{(CW-6){1'b0}}, r_eff});

    assign rs_v = bdep_pkg::clip_coord(ry - r_s, h_eff);
    assign re_v = bdep_pkg::clip_coord(ry + r_s, h_eff);
    assign cs_v = bdep_pkg::clip_coord(rx - r_s, w_eff);
    assign ce_v = bdep_pkg::clip_coord(rx + r_s, w_eff);

    assign cx_ext = $signed({{(SIW-16){cx_reg[15]}}, cx_reg});
    assign cy_ext = $signed({{(SIW-16){cy_reg[15]}}, cy_reg});

    always_comb
    begin
        unique case (state_reg)
            ST_SETUP:
            begin
                sq_op = $signed({{(SIW-10){1'b0}}, r_eff, 4'b0000});
            end
            ST_ROW:
            begin
                sq_op = $signed({{(SIW-YW-4){1'b0}}, row_reg, 4'b0000}) - cy_ext;
            end
            ST_SCAN:
            begin
                sq_op = $signed({{(SIW-XW-4){1'b0}}, col_reg, 4'b0000}) - cx_ext;
            end
            default:
            begin
                sq_op = '0;
            end
        endcase
    end

    bdep_sq_unit u_sq
    (
        .clk  (clk),
        .op   (sq_op),
        .sq_q (sq_q)
    );

    assign mem_rd_addr = AW'(row_base_reg + AW'(col_reg));
    assign ev_inside   = ({1'b0, sq_q} + {1'b0, dy2_reg}) <= {1'b0, lim_reg};
    assign erase_hit   = p_valid_reg && (kind_reg == bdep_pkg::KIND_ERASE) &&
                         (mem_rd_data != bdep_pkg::ALPHA_NONE) &&
                         (mem_rd_data != bdep_pkg::ALPHA_FULL) && ev_inside;
    assign probe_hit   = p_valid_reg && (kind_reg == bdep_pkg::KIND_PROBE) &&
                         (mem_rd_data != bdep_pkg::ALPHA_NONE) && ev_inside;

    assign col_last = ((XW+1)'(col_reg) + (XW+1)'(1)) == (XW+1)'(ce_reg);
    assign row_last = ((YW+1)'(row_reg) + (YW+1)'(1)) == (YW+1)'(re_reg);

    always_comb
    begin
        if (in_accept && (s_tuser == bdep_pkg::KIND_LOAD))
        begin
            mem_wr_en   = ld_ok;
            mem_wr_addr = ld_addr;
            mem_wr_data = in_load_alpha;
        end
        else
        begin
            mem_wr_en   = erase_hit;
            mem_wr_addr = p_addr_reg;
            mem_wr_data = bdep_pkg::ALPHA_NONE;
        end
    end

    bdep_alpha_mem #(.DEPTH(DEPTH)) u_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            p_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            p_valid_reg <= (state_reg == ST_SCAN) && !probe_hit;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if ((s_tuser == bdep_pkg::KIND_ERASE) ||
                            (s_tuser == bdep_pkg::KIND_PROBE))
                        begin
                            state_reg <= ST_SETUP;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SETUP:
                begin
                    if ((rs_v < re_v) && (cs_v < ce_v))
                    begin
                        state_reg <= ST_LIM;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_LIM:
                begin
                    state_reg <= ST_ROW;
                end
                ST_ROW:
                begin
                    state_reg <= ST_ROW2;
                end
                ST_ROW2:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (probe_hit)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (col_last)
                    begin
                        state_reg <= ST_TAIL;
                    end
                end
                ST_TAIL:
                begin
                    if (probe_hit || row_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_ROW;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, res_count_reg, res_hy_reg, res_hx_reg,
                                         res_hit_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_reg      <= s_tuser;
                    cx_reg        <= $signed(in_center_x);
                    cy_reg        <= $signed(in_center_y);
                    r_reg         <= in_radius;
                    res_hit_reg   <= 1'b0;
                    res_hx_reg    <= '0;
                    res_hy_reg    <= '0;
                    res_count_reg <= '0;
                end
            end
            ST_SETUP:
            begin
                re_reg       <= re_v[YW-1:0];
                cs_reg       <= cs_v[XW-1:0];
                ce_reg       <= ce_v[XW-1:0];
                row_reg      <= rs_v[YW-1:0];
                row_base_reg <= AW'(32'(rs_v[YW-1:0]) * 32'(MAX_WIDTH));
            end
            ST_LIM:
            begin
                lim_reg <= sq_q;
            end
            ST_ROW:
            begin
                col_reg <= cs_reg;
            end
            ST_ROW2:
            begin
                dy2_reg <= sq_q;
            end
            ST_SCAN:
            begin
                col_reg    <= XW'(col_reg + XW'(1));
                p_col_reg  <= col_reg;
                p_addr_reg <= mem_rd_addr;
            end
            ST_TAIL:
            begin
                row_reg      <= YW'(row_reg + YW'(1));
                row_base_reg <= AW'(row_base_reg + AW'(MAX_WIDTH));
            end
            default:
            begin
            end
        endcase
        if (erase_hit)
        begin
            res_count_reg <= 14'(res_count_reg + 14'd1);
        end
        if (probe_hit)
        begin
            res_hit_reg <= 1'b1;
            res_hx_reg  <= 9'(p_col_reg);
            res_hy_reg  <= 9'(row_reg);
        end
    end

    `BDEP_ASSERT_NEXT(a_busy_after_accept, (s_tvalid && s_tready), (!s_tready))
    `BDEP_ASSERT_IMPL(a_pipe_in_scan, p_valid_reg, ((state_reg == ST_SCAN) || (state_reg == ST_TAIL)))
    `BDEP_ASSERT_IMPL(a_col_in_window, (state_reg == ST_SCAN), (col_reg < ce_reg))
    `BDEP_ASSERT_IMPL(a_scan_write_erase, (mem_wr_en && (state_reg != ST_IDLE)), (kind_reg == bdep_pkg::KIND_ERASE))

endmodule

// ===== tb/tb_bitmap_disk_erase_and_probe_core.sv =====
// Self-checking testbench for the terrain bitmap disk erase and probe core.
`timescale 1ns / 1ps

module tb_bitmap_disk_erase_and_probe_core;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int BITMAP_W    = 512;
    localparam int FILL_SPAN   = 8;
    localparam int CORNER_BASE = 508;
    localparam int PHASE_ITEMS = 7;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT = 100000;

    typedef struct packed {
        logic [5:0]         radius;
        logic signed [15:0] center_y;
        logic signed [15:0] center_x;
        logic [7:0]         load_alpha;
        logic [8:0]         load_y;
        logic [8:0]         load_x;
    } disk_item_t;

    typedef struct packed {
        logic [6:0]  pad;
        logic [13:0] erased_count;
        logic [8:0]  hit_y;
        logic [8:0]  hit_x;
        logic        hit;
    } disk_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic [bdep_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]                      s_tuser = bdep_pkg::KIND_LOAD;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bdep_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [2:0]                      paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    bit [7:0]     alpha_img [0:BITMAP_W*BITMAP_W-1];
    bit           pix_written [0:BITMAP_W*BITMAP_W-1];
    bit [9:0]     stage_w_cfg = 10'd512;
    bit [9:0]     stage_h_cfg = 10'd512;
    disk_result_t expected_q [$];
    int           errors = 0;
    int           burst_left = 0;
    int           quiet_cycles = 0;
    int           ready_mode = 0;
    int           ready_span = 0;

    bitmap_disk_erase_and_probe_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic int stage_extent(input bit [9:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > BITMAP_W)
        begin
            return BITMAP_W;
        end
        return int'(v);
    endfunction

    function automatic int clamp_edge(input int v, input int hi);
        if (v < 0)
        begin
            return 0;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void disk_window(input int cx, input int cy, input int r,
                                        output int rs, output int re,
                                        output int cs, output int ce);
        int w;
        int h;
        int rx;
        int ry;
        w  = stage_extent(stage_w_cfg);
        h  = stage_extent(stage_h_cfg);
        rx = (cx + 8) >>> 4;
        ry = (cy + 8) >>> 4;
        rs = clamp_edge(ry - r, h);
        re = clamp_edge(ry + r, h);
        cs = clamp_edge(rx - r, w);
        ce = clamp_edge(rx + r, w);
    endfunction

    function automatic bit window_defined(input int cx, input int cy, input int r);
        int rs;
        int re;
        int cs;
        int ce;
        disk_window(cx, cy, r, rs, re, cs, ce);
        for (int i = rs; i < re; i++)
        begin
            for (int j = cs; j < ce; j++)
            begin
                if (!pix_written[i * BITMAP_W + j])
                begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic disk_result_t predict_terrain_op(input logic [1:0] kind,
                                                        input disk_item_t f);
        disk_result_t res;
        int           cx;
        int           cy;
        int           r;
        int           rs;
        int           re;
        int           cs;
        int           ce;
        int           addr;
        longint       lim;
        longint       dx;
        longint       dy;
        bit           found;
        res   = '0;
        found = 1'b0;
        if (kind == bdep_pkg::KIND_LOAD)
        begin
            addr = int'({f.load_y, f.load_x});
            alpha_img[addr]   = f.load_alpha;
            pix_written[addr] = 1'b1;
        end
        else if (kind == bdep_pkg::KIND_ERASE || kind == bdep_pkg::KIND_PROBE)
        begin
            cx  = int'($signed(f.center_x));
            cy  = int'($signed(f.center_y));
            r   = int'(f.radius);
            lim = longint'(r) * r * 256;
            disk_window(cx, cy, r, rs, re, cs, ce);
            for (int i = rs; i < re && !found; i++)
            begin
                for (int j = cs; j < ce; j++)
                begin
                    addr = i * BITMAP_W + j;
                    dx   = longint'(j) * 16 - cx;
                    dy   = longint'(i) * 16 - cy;
                    if (dx * dx + dy * dy <= lim)
                    begin
                        if (kind == bdep_pkg::KIND_ERASE)
                        begin
                            if (alpha_img[addr] != bdep_pkg::ALPHA_NONE &&
                                alpha_img[addr] != bdep_pkg::ALPHA_FULL)
                            begin
                                alpha_img[addr]  = bdep_pkg::ALPHA_NONE;
                                res.erased_count = res.erased_count + 1'b1;
                            end
                        end
                        else if (alpha_img[addr] != bdep_pkg::ALPHA_NONE)
                        begin
                            res.hit   = 1'b1;
                            res.hit_x = 9'(j);
                            res.hit_y = 9'(i);
                            found     = 1'b1;
                            break;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic bit [7:0] rand_alpha();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 4)
        begin
            return bdep_pkg::ALPHA_NONE;
        end
        if (pick < 7)
        begin
            return bdep_pkg::ALPHA_FULL;
        end
        return 8'($urandom_range(1, 254));
    endfunction

    function automatic disk_item_t load_op(input int x, input int y, input bit [7:0] a);
        disk_item_t f;
        f            = {$urandom, $urandom};
        f.load_x     = 9'(x);
        f.load_y     = 9'(y);
        f.load_alpha = a;
        return f;
    endfunction

    function automatic disk_item_t disk_op(input int cx, input int cy, input int r);
        disk_item_t f;
        f          = {$urandom, $urandom};
        f.center_x = 16'(cx);
        f.center_y = 16'(cy);
        f.radius   = 6'(r);
        return f;
    endfunction

    function automatic disk_item_t random_load();
        int x;
        int y;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            x = $urandom_range(0, BITMAP_W - 1);
            y = $urandom_range(0, BITMAP_W - 1);
        end
        else if (pick < 4)
        begin
            x = CORNER_BASE + $urandom_range(0, BITMAP_W - 1 - CORNER_BASE);
            y = CORNER_BASE + $urandom_range(0, BITMAP_W - 1 - CORNER_BASE);
        end
        else
        begin
            x = $urandom_range(0, FILL_SPAN - 1);
            y = $urandom_range(0, FILL_SPAN - 1);
        end
        return load_op(x, y, rand_alpha());
    endfunction

    function automatic disk_item_t random_disk();
        int px;
        int py;
        int cx;
        int cy;
        int r;
        bit ok;
        ok = 1'b0;
        for (int tries = 0; tries < 30 && !ok; tries++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cx = int'($signed(16'($urandom)));
                cy = int'($signed(16'($urandom)));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    px = CORNER_BASE - 6 + $urandom_range(0, 19);
                    py = CORNER_BASE - 6 + $urandom_range(0, 19);
                end
                else
                begin
                    px = $urandom_range(0, FILL_SPAN + 5) - 3;
                    py = $urandom_range(0, FILL_SPAN + 5) - 3;
                end
                cx = px * 16 + $urandom_range(0, 15) - 8;
                cy = py * 16 + $urandom_range(0, 15) - 8;
            end
            r  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 10);
            ok = window_defined(cx, cy, r);
        end
        if (!ok)
        begin
            r = 0;
        end
        return disk_op(cx, cy, r);
    endfunction

    task automatic send_item(input logic [1:0] kind, input disk_item_t f);
        int gap;
        @(negedge clk);
        s_tuser  <= kind;
        s_tdata  <= f;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        expected_q.insert(expected_q.size(), predict_terrain_op(kind, f));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stage_reg(input logic [1:0] idx, input bit [9:0] value);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == bdep_pkg::CFG_STAGE_WIDTH)
        begin
            stage_w_cfg = value;
        end
        else
        begin
            stage_h_cfg = value;
        end
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != 32'(value))
        begin
            errors++;
            $display("%0t register %0d readback: expected %0d actual %0d",
                     $time, idx, value, rd);
        end
    endtask

    task automatic configure_stage(input bit [9:0] w, input bit [9:0] h);
        wait_idle();
        write_stage_reg(bdep_pkg::CFG_STAGE_WIDTH, w);
        write_stage_reg(bdep_pkg::CFG_STAGE_HEIGHT, h);
    endtask

    task automatic test_bitmap_fill();
        for (int y = 0; y < FILL_SPAN; y++)
        begin
            for (int x = 0; x < FILL_SPAN; x++)
            begin
                send_item(bdep_pkg::KIND_LOAD, load_op(x, y, rand_alpha()));
            end
        end
        for (int y = CORNER_BASE; y < BITMAP_W; y++)
        begin
            for (int x = CORNER_BASE; x < BITMAP_W; x++)
            begin
                send_item(bdep_pkg::KIND_LOAD, load_op(x, y, rand_alpha()));
            end
        end
    endtask

    task automatic test_zero_radius();
        send_item(bdep_pkg::KIND_ERASE, disk_op(5 * 16, 5 * 16, 0));
        send_item(bdep_pkg::KIND_PROBE, disk_op(5 * 16, 5 * 16, 0));
    endtask

    task automatic test_center_rounding();
        send_item(bdep_pkg::KIND_PROBE, disk_op(16'sh0058, 16'sh0057, 2));
        send_item(bdep_pkg::KIND_PROBE, disk_op(-8, -9, 3));
        send_item(bdep_pkg::KIND_ERASE, disk_op(-36, 3 * 16, 5));
    endtask

    task automatic test_probe_miss();
        send_item(bdep_pkg::KIND_LOAD, load_op(10, 10, bdep_pkg::ALPHA_NONE));
        send_item(bdep_pkg::KIND_LOAD, load_op(11, 10, bdep_pkg::ALPHA_NONE));
        send_item(bdep_pkg::KIND_LOAD, load_op(10, 11, bdep_pkg::ALPHA_NONE));
        send_item(bdep_pkg::KIND_LOAD, load_op(11, 11, bdep_pkg::ALPHA_NONE));
        send_item(bdep_pkg::KIND_PROBE, disk_op(10 * 16 + 8, 10 * 16 + 8, 1));
    endtask

    task automatic test_full_alpha_kept();
        send_item(bdep_pkg::KIND_LOAD, load_op(510, 510, bdep_pkg::ALPHA_FULL));
        send_item(bdep_pkg::KIND_LOAD, load_op(509, 510, 8'h7F));
        send_item(bdep_pkg::KIND_ERASE, disk_op(510 * 16, 510 * 16, 2));
        send_item(bdep_pkg::KIND_PROBE, disk_op(510 * 16, 510 * 16, 2));
    endtask

    task automatic test_unknown_kind();
        send_item(KIND_UNUSED, '1);
        send_item(KIND_UNUSED, '0);
    endtask

    task automatic test_far_centers();
        send_item(bdep_pkg::KIND_ERASE, disk_op(-32768, 32767, 63));
        send_item(bdep_pkg::KIND_PROBE, disk_op(32767, -32768, 63));
        send_item(bdep_pkg::KIND_PROBE, disk_op(32767, 32767, 63));
        send_item(bdep_pkg::KIND_ERASE, disk_op(-32768, -32768, 63));
    endtask

    task automatic test_stage_limits();
        configure_stage(10'd8, 10'd8);
        send_item(bdep_pkg::KIND_ERASE, disk_op(4 * 16, 4 * 16, 63));
        send_item(bdep_pkg::KIND_PROBE, disk_op(4 * 16, 4 * 16, 63));
        configure_stage(10'd1023, 10'd0);
        send_item(bdep_pkg::KIND_ERASE, disk_op(-58 * 16, -58 * 16, 63));
        send_item(bdep_pkg::KIND_PROBE, disk_op(3 * 16, 0, 1));
    endtask

    task automatic test_random_traffic();
        bit [9:0] phase_w [5] = '{10'd0, 10'd20, 10'd1023, 10'd512, 10'd7};
        bit [9:0] phase_h [5] = '{10'd1, 10'd13, 10'd600, 10'd512, 10'd24};
        int       sent;
        int       pick;
        for (int p = 0; p < 5; p++)
        begin
            configure_stage(phase_w[p], phase_h[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                begin
                    send_item(KIND_UNUSED, {$urandom, $urandom});
                end
                else
                begin
                    if (pick < 34)
                    begin
                        send_item(bdep_pkg::KIND_LOAD, random_load());
                    end
                    else if (pick < 67)
                    begin
                        send_item(bdep_pkg::KIND_ERASE, random_disk());
                    end
                    else
                    begin
                        send_item(bdep_pkg::KIND_PROBE, random_disk());
                    end
                    sent++;
                end
            end
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_span = $urandom_range(8, 80);
        end
        ready_span--;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        disk_result_t got;
        disk_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = disk_result_t'(m_tdata);
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
            end
            else
            begin
                want = expected_q.pop_front();
                report_field("hit", want.hit, got.hit);
                report_field("hit_x", want.hit_x, got.hit_x);
                report_field("hit_y", want.hit_y, got.hit_y);
                report_field("erased_count", want.erased_count, got.erased_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("bitmap_disk_erase_and_probe_core test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_bitmap_fill();
        test_zero_radius();
        test_center_rounding();
        test_probe_miss();
        test_full_alpha_kept();
        test_unknown_kind();
        test_far_centers();
        test_stage_limits();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
        begin
            $display("bitmap_disk_erase_and_probe_core test passed");
        end
        else
        begin
            $display("bitmap_disk_erase_and_probe_core test failed");
        end
        $finish;
    end

endmodule
